@@ rtl/core/lst_pkg.sv @@
package lst_pkg;

  localparam int SpeedW = 9;
  localparam int SumW = SpeedW + 1;
  localparam int TimeW = 32;
  localparam int SplitW = 16;
  localparam int DistW = 32;
  localparam int DistMarkW = 16;
  localparam int NumSplits = 4;
  localparam int NumMarks = 3;

  localparam logic [SpeedW-1:0] MarkOneRst = 9'd60;
  localparam logic [SpeedW-1:0] MarkTwoRst = 9'd100;
  localparam logic [SpeedW-1:0] MarkThreeRst = 9'd200;
  localparam logic [DistMarkW-1:0] DistMarkRst = 16'd400;

  // Distance increment is floor(sum * dt / 7200), with 7200 = 32 * 225.
  localparam int DistPreShift = 5;
  localparam int DistDiv = 225;
  localparam int ProdW = SumW + TimeW;
  localparam int HiW = ProdW - DistPreShift - 16;
  localparam int HiShift = HiW + 8;
  localparam int RecipHiW = 22;
  localparam int QuotHiW = HiW + RecipHiW - HiShift;
  localparam int RemW = 24;
  localparam int LoShift = RemW + 8;
  localparam int RecipLoW = 25;
  localparam logic [RecipHiW-1:0] RecipHi =
      RecipHiW'(((64'd1 << HiShift) + 64'(DistDiv) - 64'd1) / 64'(DistDiv));
  localparam logic [RecipLoW-1:0] RecipLo =
      RecipLoW'(((64'd1 << LoShift) + 64'(DistDiv) - 64'd1) / 64'(DistDiv));

  // Tenths of a second: floor(ms / 100) by reciprocal.
  localparam int TenthsShift = 38;
  localparam logic [TimeW-1:0] RecipTenths =
      TimeW'(((64'd1 << TenthsShift) + 64'd99) / 64'd100);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_RUN   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_MARK_ONE   = 2'd0,
    REG_MARK_TWO   = 2'd1,
    REG_MARK_THREE = 2'd2,
    REG_DIST_MARK  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SpeedW-1:0]    mark_one;
    logic [SpeedW-1:0]    mark_two;
    logic [SpeedW-1:0]    mark_three;
    logic [DistMarkW-1:0] dist_mark;
  } cfg_t;

  typedef struct packed {
    phase_e              phase;
    logic                start;
    logic                run;
    logic [NumMarks-1:0] hit;
    logic                done;
  } ctl_t;

endpackage

@@ rtl/core/launch_split_timer_top.sv @@
// Launch split timer: times a standing start from timestamped speed samples.
// Each request on the input channel (in_valid_i/in_ready_o) carries one speed
// sample in kph and its free-running millisecond time stamp. Each request
// yields exactly one result on the output channel (out_valid_o/out_ready_i):
// the phase after the sample, the four recorded splits in tenths of a second,
// the integrated distance in meters and a flag that marks the end of a run.
// A new request is taken in every cycle while in_ready_o is high; the
// five-stage arithmetic pipeline (two multiply and reciprocal-division steps
// for the distance and one for the tenths) lies between acceptance and the
// result register, while the phase machine and previous-sample registers
// update in the accepting cycle. Each pipeline stage holds its item while the
// stage after it is full, so when the receiver stalls the bubbles fill up
// first and in_ready_o drops only once the five stages and the result
// register all hold requests.
// Reset clears the phase to idle, the distance, the splits and the previous
// sample, and loads the default speed and distance marks. The marks are
// written over the APB port; a write must only happen while no request is in
// flight.
module launch_split_timer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lst_pkg::SpeedW-1:0]    speed_kph_i,
  input  logic [lst_pkg::TimeW-1:0]     now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    phase_o,
  output logic [lst_pkg::SplitW-1:0]    split_one_o,
  output logic [lst_pkg::SplitW-1:0]    split_two_o,
  output logic [lst_pkg::SplitW-1:0]    split_three_o,
  output logic [lst_pkg::SplitW-1:0]    split_distance_o,
  output logic [lst_pkg::DistW-1:0]     travelled_m_o,
  output logic                          run_done_o
);
  import lst_pkg::*;

  cfg_t             cfg;
  ctl_t             front_ctl, pipe_ctl;
  logic [SumW-1:0]  sum;
  logic [TimeW-1:0] dt, elapsed;
  logic             accept;
  logic             pipe_valid, res_take;
  logic [DistW-1:0] inc;
  logic [SplitW-1:0] tenths;

  assign accept = in_valid_i && in_ready_o;

  // Mark registers and their read-back.
  lst_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Phase machine and the time differences, decided when a request is taken.
  lst_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .speed_i   (speed_kph_i),
    .now_i     (now_ms_i),
    .cfg_i     (cfg),
    .ctl_o     (front_ctl),
    .sum_o     (sum),
    .dt_o      (dt),
    .elapsed_o (elapsed)
  );

  // Distance increment and elapsed tenths, computed over five stages.
  lst_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .ctl_i     (front_ctl),
    .sum_i     (sum),
    .dt_i      (dt),
    .elapsed_i (elapsed),
    .valid_o   (pipe_valid),
    .take_i    (res_take),
    .ctl_o     (pipe_ctl),
    .inc_o     (inc),
    .tenths_o  (tenths)
  );

  // Distance accumulator, split store and the result register.
  lst_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (pipe_valid),
    .take_o           (res_take),
    .ctl_i            (pipe_ctl),
    .inc_i            (inc),
    .tenths_i         (tenths),
    .dist_mark_i      (cfg.dist_mark),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .phase_o          (phase_o),
    .split_one_o      (split_one_o),
    .split_two_o      (split_two_o),
    .split_three_o    (split_three_o),
    .split_distance_o (split_distance_o),
    .travelled_m_o    (travelled_m_o),
    .run_done_o       (run_done_o)
  );

endmodule

@@ rtl/core/lst_cfg_regs.sv @@
module lst_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lst_pkg::cfg_t cfg_o
);
  import lst_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark_one <= MarkOneRst;
      cfg_q.mark_two <= MarkTwoRst;
      cfg_q.mark_three <= MarkThreeRst;
      cfg_q.dist_mark <= DistMarkRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_MARK_ONE:   cfg_q.mark_one <= pwdata[SpeedW-1:0];
        REG_MARK_TWO:   cfg_q.mark_two <= pwdata[SpeedW-1:0];
        REG_MARK_THREE: cfg_q.mark_three <= pwdata[SpeedW-1:0];
        REG_DIST_MARK:  cfg_q.dist_mark <= pwdata[DistMarkW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MARK_ONE:   prdata = 32'(cfg_q.mark_one);
      REG_MARK_TWO:   prdata = 32'(cfg_q.mark_two);
      REG_MARK_THREE: prdata = 32'(cfg_q.mark_three);
      REG_DIST_MARK:  prdata = 32'(cfg_q.dist_mark);
    endcase
  end

endmodule

@@ rtl/core/lst_front.sv @@
module lst_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [lst_pkg::SpeedW-1:0]    speed_i,
  input  logic [lst_pkg::TimeW-1:0]     now_i,
  input  lst_pkg::cfg_t                 cfg_i,
  output lst_pkg::ctl_t                 ctl_o,
  output logic [lst_pkg::SumW-1:0]      sum_o,
  output logic [lst_pkg::TimeW-1:0]     dt_o,
  output logic [lst_pkg::TimeW-1:0]     elapsed_o
);
  import lst_pkg::*;

  phase_e              phase_q, phase_d;
  logic [SpeedW-1:0]   prev_speed_q;
  logic [TimeW-1:0]    prev_time_q;
  logic [TimeW-1:0]    start_time_q;
  logic                zero;
  logic [NumMarks-1:0] hit;
  logic                start, run, done;

  assign zero = (speed_i == '0);
  assign hit = {speed_i >= cfg_i.mark_three, speed_i >= cfg_i.mark_two,
                speed_i >= cfg_i.mark_one};

  // Next phase. Inside a run the third split is always still open, since
  // recording it ends the run.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_ARMED: begin
        if (zero) phase_d = PH_RUN;
      end
      PH_RUN: begin
        if (hit[2] || zero) phase_d = PH_IDLE;
      end
      default: begin
        phase_d = zero ? PH_ARMED : PH_IDLE;
      end
    endcase
  end

  always_comb begin
    start = (phase_q == PH_ARMED) && zero;
    run = (phase_q == PH_RUN);
    done = run && hit[2];
  end

  assign ctl_o = '{phase: phase_d, start: start, run: run, hit: hit, done: done};
  assign sum_o = {1'b0, speed_i} + {1'b0, prev_speed_q};
  assign dt_o = now_i - prev_time_q;
  assign elapsed_o = now_i - start_time_q;

  // A run starts only on a zero sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_speed_q <= '0;
      prev_time_q <= '0;
      start_time_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      prev_speed_q <= speed_i;
      prev_time_q <= now_i;
      if (start) start_time_q <= now_i;
    end
  end

endmodule

@@ rtl/core/lst_pipe.sv @@
module lst_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  lst_pkg::ctl_t               ctl_i,
  input  logic [lst_pkg::SumW-1:0]    sum_i,
  input  logic [lst_pkg::TimeW-1:0]   dt_i,
  input  logic [lst_pkg::TimeW-1:0]   elapsed_i,
  output logic                        valid_o,
  input  logic                        take_i,
  output lst_pkg::ctl_t               ctl_o,
  output logic [lst_pkg::DistW-1:0]   inc_o,
  output logic [lst_pkg::SplitW-1:0]  tenths_o
);
  import lst_pkg::*;

  localparam int Stages = 5;

  logic [Stages-1:0] vld_q, en;
  ctl_t              ctl_q [Stages];

  logic [SumW-1:0]   sum1_q;
  logic [TimeW-1:0]  dt1_q, el1_q;
  logic [ProdW-1:0]  prod2_q;
  logic [2*TimeW-1:0] tprod2_q;
  logic [HiW-1:0]    yh3_q;
  logic [15:0]       yl3_q;
  logic [HiW+RecipHiW-1:0] hiprod3_q;
  logic [SplitW-1:0] tenths3_q, tenths4_q, tenths5_q;
  logic [QuotHiW-1:0] qh4_q, qh5_q;
  logic [RemW-1:0]   rem4_q;
  logic [RemW+RecipLoW-1:0] loprod5_q;

  logic [QuotHiW-1:0] qh_w;
  logic [HiW-1:0]     hi_sub;
  logic [SplitW-1:0]  tenths_w;

  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || take_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) ctl_q[0] <= ctl_i;
    for (int k = 1; k < Stages; k++) begin
      if (en[k]) ctl_q[k] <= ctl_q[k-1];
    end
  end

  assign qh_w = hiprod3_q[HiW+RecipHiW-1:HiShift];
  assign hi_sub = yh3_q - HiW'({{(HiW-QuotHiW){1'b0}}, qh_w} * HiW'(DistDiv));
  assign tenths_w = (|tprod2_q[2*TimeW-1:TenthsShift+SplitW]) ? '1
                  : tprod2_q[TenthsShift+SplitW-1:TenthsShift];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sum1_q <= sum_i;
      dt1_q <= dt_i;
      el1_q <= elapsed_i;
    end
    if (en[1]) begin
      prod2_q <= ProdW'(sum1_q) * ProdW'(dt1_q);
      tprod2_q <= (2*TimeW)'(el1_q) * (2*TimeW)'(RecipTenths);
    end
    if (en[2]) begin
      yh3_q <= prod2_q[ProdW-1:ProdW-HiW];
      yl3_q <= prod2_q[DistPreShift+15:DistPreShift];
      hiprod3_q <= (HiW+RecipHiW)'(prod2_q[ProdW-1:ProdW-HiW])
                 * (HiW+RecipHiW)'(RecipHi);
      tenths3_q <= tenths_w;
    end
    if (en[3]) begin
      qh4_q <= qh_w;
      rem4_q <= {hi_sub[7:0], yl3_q};
      tenths4_q <= tenths3_q;
    end
    if (en[4]) begin
      qh5_q <= qh4_q;
      loprod5_q <= (RemW+RecipLoW)'(rem4_q) * (RemW+RecipLoW)'(RecipLo);
      tenths5_q <= tenths4_q;
    end
  end

  // The low quotient is below 2^16 because its dividend is below 225 * 2^16.
  assign inc_o = DistW'({qh5_q, loprod5_q[LoShift+15:LoShift]});
  assign tenths_o = tenths5_q;
  assign ctl_o = ctl_q[Stages-1];
  assign valid_o = vld_q[Stages-1];

endmodule

@@ rtl/core/lst_result.sv @@
module lst_result (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           take_o,
  input  lst_pkg::ctl_t                  ctl_i,
  input  logic [lst_pkg::DistW-1:0]      inc_i,
  input  logic [lst_pkg::SplitW-1:0]     tenths_i,
  input  logic [lst_pkg::DistMarkW-1:0]  dist_mark_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     phase_o,
  output logic [lst_pkg::SplitW-1:0]     split_one_o,
  output logic [lst_pkg::SplitW-1:0]     split_two_o,
  output logic [lst_pkg::SplitW-1:0]     split_three_o,
  output logic [lst_pkg::SplitW-1:0]     split_distance_o,
  output logic [lst_pkg::DistW-1:0]      travelled_m_o,
  output logic                           run_done_o
);
  import lst_pkg::*;

  localparam int DistIdx = NumSplits - 1;

  logic              out_valid_q;
  phase_e            phase_q;
  logic              done_q;
  logic [DistW-1:0]  acc_q, acc_d;
  logic [SplitW-1:0] split_q [NumSplits];
  logic [SplitW-1:0] split_d [NumSplits];
  logic              load;

  assign take_o = !out_valid_q || out_ready_i;
  assign load = valid_i && take_o;

  always_comb begin
    acc_d = ctl_i.start ? '0 : acc_q + inc_i;
    for (int i = 0; i < NumSplits; i++) begin
      split_d[i] = ctl_i.start ? '0 : split_q[i];
    end
    if (ctl_i.run) begin
      for (int i = 0; i < NumMarks; i++) begin
        if (split_q[i] == '0 && ctl_i.hit[i]) split_d[i] = tenths_i;
      end
      if (split_q[DistIdx] == '0 && acc_d >= DistW'(dist_mark_i)) begin
        split_d[DistIdx] = tenths_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q <= PH_IDLE;
      done_q <= 1'b0;
      acc_q <= '0;
      for (int i = 0; i < NumSplits; i++) split_q[i] <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q <= ctl_i.phase;
        done_q <= ctl_i.done;
        acc_q <= acc_d;
        for (int i = 0; i < NumSplits; i++) split_q[i] <= split_d[i];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_o = phase_q;
  assign split_one_o = split_q[0];
  assign split_two_o = split_q[1];
  assign split_three_o = split_q[2];
  assign split_distance_o = split_q[DistIdx];
  assign travelled_m_o = acc_q;
  assign run_done_o = done_q;

endmodule
